>>> hdl/distinct_value_count_store_unit_assert.svh
// Assertion macros for the distinct value count store.
// Used by the port checker; no other dependencies.
`ifndef DISTINCT_VALUE_COUNT_STORE_UNIT_ASSERT_SVH
`define DISTINCT_VALUE_COUNT_STORE_UNIT_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define DVCS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Antecedent at one edge implies the consequent at the following edge.
`define DVCS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/dvcs_pkg.sv
// Shared types, sizes and codes for the distinct value count store.
// No dependencies; imported by every module of the block but the RAM.
`default_nettype none

package dvcs_pkg;

  // Table geometry and count width.
  localparam int ENTRIES     = 16384;
  localparam int COUNT_WIDTH = 32;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int DIST_W      = $clog2(ENTRIES + 1);
  localparam int SPAN_W      = $clog2(ENTRIES + 1);

  // Shared adder is wide enough for a count plus a merge count, and for offsets.
  localparam int ALU_W = ((COUNT_WIDTH > 32) ? COUNT_WIDTH : 32) + 1;

  // Fixed field widths of the item and result.
  localparam int OPC_W  = 3;
  localparam int VAL_W  = 16;
  localparam int KIDX_W = 14;
  localparam int MC_W   = 32;
  localparam int CNT_W  = 32;
  localparam int DOUT_W = 15;

  localparam int S_TDATA_W = 64;
  localparam int M_TDATA_W = 72;
  localparam int CFG_IDX_W = 1;

  // Configuration reset values.
  localparam logic signed [VAL_W-1:0] VMIN_RST = -16'sd5000;
  localparam logic signed [VAL_W-1:0] VMAX_RST = 16'sd5000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_MIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_MAX = 1'b1;

  typedef enum logic [OPC_W-1:0] {
    OP_ADD    = 3'd0,
    OP_QUERY  = 3'd1,
    OP_SELECT = 3'd2,
    OP_MERGE  = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_OFFS,
    ST_RD,
    ST_MOD,
    ST_SEL_RD,
    ST_SEL_CHK,
    ST_VOUT,
    ST_DONE
  } state_e;

  // One result item.
  typedef struct packed {
    logic              is_new;
    logic              found;
    logic [VAL_W-1:0]  value_out;
    logic [CNT_W-1:0]  count_out;
    logic              out_of_range;
    logic [DOUT_W-1:0] distinct_out;
  } res_t;

  // Low bits of a count as the result field.
  function automatic logic [CNT_W-1:0] count_field(input logic [COUNT_WIDTH-1:0] c);
    logic [63:0] wide;
    wide = 64'(c);
    return wide[CNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hdl/dvcs_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies; holds the count table.
`default_nettype none

module dvcs_ram #(
  parameter int DEPTH  = 16384,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One access a cycle; a read returns data on the following cycle.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem[addr_i];
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/dvcs_alu.sv
// Shared adder/subtractor with a saturated count output.
// Depends on dvcs_pkg for widths and the operation code.
`default_nettype none

module dvcs_alu (
  input  dvcs_pkg::alu_op_e                     op_i,
  input  logic [dvcs_pkg::ALU_W-1:0]            a_i,
  input  logic [dvcs_pkg::ALU_W-1:0]            b_i,
  output logic [dvcs_pkg::ALU_W-1:0]            sum_o,
  output logic [dvcs_pkg::COUNT_WIDTH-1:0]      sat_o
);
  import dvcs_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  logic [ALU_W-1:0] b_eff;
  logic             sub;

  // Subtraction is an add of the inverted operand with a carry in.
  assign sub   = (op_i == ALU_SUB);
  assign b_eff = sub ? ~b_i : b_i;
  assign sum_o = a_i + b_eff + ALU_W'(sub);

  // Any bit above the count width means the count has passed its largest value.
  assign sat_o = (|sum_o[ALU_W-1:COUNT_WIDTH]) ? COUNT_MAX : sum_o[COUNT_WIDTH-1:0];

endmodule

`default_nettype wire

>>> hdl/distinct_value_count_store_unit.sv
// Top level of the distinct value count store: sequencer, count table and shared adder.
// Depends on dvcs_pkg, dvcs_ram and dvcs_alu.
//
//  Channel  Direction  Transfer when              Contents
//  s_axis   in         tvalid & tready            tuser opcode, tdata value/index/merge count
//  m_axis   out        tvalid & tready            tdata result flags, value, count, distinct
//  cfg      in         cfg_valid_i & cfg_ready_o  register index and 16-bit data
//
// Add, query and merge go from the input transfer to the result register through the
// offset, table read, update and result load steps; offset and update use the shared adder.
// Select takes the shortcut or walks up to span entries of the table, with a read and
// a check step per entry. Clear runs a clearing pass over every entry of the table.
// After reset a clearing pass over all ENTRIES (16384) entries runs with s_axis_tready low;
// configuration writes are taken throughout. A stalled result holds the next one in
// ST_DONE, and s_axis_tready stays low until the output register frees up.
`default_nettype none

module distinct_value_count_store_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input items
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata from bit 0: value[15:0], entry_index[29:16], merge_count[61:30], zeros[63:62]
  input  logic [dvcs_pkg::S_TDATA_W-1:0]      s_axis_tdata,
  // tuser from bit 0: opcode[2:0]
  input  logic [dvcs_pkg::OPC_W-1:0]          s_axis_tuser,
  // Result items
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata from bit 0: is_new[0], found[1], value_out[17:2], count_out[49:18],
  // out_of_range[50], distinct_out[65:51], zeros[71:66]
  output logic [dvcs_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  // Configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dvcs_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [dvcs_pkg::VAL_W-1:0]          cfg_data_i
);
  import dvcs_pkg::*;

  localparam int SPW = $clog2(ENTRIES + 1) + 3 > 18 ? $clog2(ENTRIES + 1) + 3 : 18;

  state_e                   state_q, state_d;
  logic [OPC_W-1:0]         op_q, op_d;
  logic [VAL_W-1:0]         v_q, v_d;
  logic [KIDX_W-1:0]        k_q, k_d;
  logic [MC_W-1:0]          mc_q, mc_d;
  logic [IDX_W-1:0]         addr_q, addr_d;
  logic [DIST_W-1:0]        seen_q, seen_d;
  logic [DIST_W-1:0]        distinct_q, distinct_d;
  logic                     reply_q, reply_d;
  res_t                     res_q, res_d;
  res_t                     out_q, out_d;
  logic                     out_valid_q, out_valid_d;
  logic signed [VAL_W-1:0]  vmin_q, vmax_q;

  logic                     mem_en, mem_we;
  logic [COUNT_WIDTH-1:0]   mem_wdata, mem_rdata;

  alu_op_e                  alu_op;
  logic [ALU_W-1:0]         alu_a, alu_b, alu_sum;
  logic [COUNT_WIDTH-1:0]   alu_sat;

  logic signed [SPW-1:0]    span_diff;
  logic [SPAN_W-1:0]        span;
  logic                     in_xfer;
  logic                     v_in_span;
  logic                     k_in_span;
  logic                     out_free;

  // Configuration registers; the user must write them only while the block is idle, which the block does not enforce.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vmin_q <= VMIN_RST;
      vmax_q <= VMAX_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_VALUE_MIN) begin
        vmin_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_VALUE_MAX) begin
        vmax_q <= cfg_data_i;
      end
    end
  end

  // Span size, clamped to zero below and to the table size above.
  assign span_diff = SPW'(vmax_q) - SPW'(vmin_q) + SPW'(1);

  always_comb begin
    if (span_diff < 0) begin
      span = '0;
    end else if (span_diff > SPW'(ENTRIES)) begin
      span = SPAN_W'(ENTRIES);
    end else begin
      span = SPAN_W'(span_diff);
    end
  end

  dvcs_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (COUNT_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (addr_q),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  dvcs_alu u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sum_o (alu_sum),
    .sat_o (alu_sat)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // In the offset step the adder holds value - value_min.
  assign v_in_span = !alu_sum[ALU_W-1] && (alu_sum < ALU_W'(span));
  assign k_in_span = 32'(k_q) < 32'(span);

  // Sequencer: next state, memory access and adder operands.
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    v_d         = v_q;
    k_d         = k_q;
    mc_d        = mc_q;
    addr_d      = addr_q;
    seen_d      = seen_q;
    distinct_d  = distinct_q;
    reply_d     = reply_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    mem_en      = 1'b0;
    mem_we      = 1'b0;
    mem_wdata   = '0;
    alu_op      = ALU_ADD;
    alu_a       = '0;
    alu_b       = '0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      // Zero one table entry a cycle.
      ST_CLEAR: begin
        mem_en = 1'b1;
        mem_we = 1'b1;
        addr_d = addr_q + IDX_W'(1);
        if (32'(addr_q) == ENTRIES - 1) begin
          addr_d  = '0;
          state_d = reply_q ? ST_DONE : ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_xfer) begin
          op_d    = s_axis_tuser;
          v_d     = s_axis_tdata[15:0];
          k_d     = s_axis_tdata[29:16];
          mc_d    = s_axis_tdata[61:30];
          res_d   = '0;
          state_d = ST_OFFS;
        end
      end

      // Offset of the value into the span, then dispatch on the opcode.
      ST_OFFS: begin
        alu_op  = ALU_SUB;
        alu_a   = {{(ALU_W-VAL_W){v_q[VAL_W-1]}}, v_q};
        alu_b   = {{(ALU_W-VAL_W){vmin_q[VAL_W-1]}}, vmin_q};
        state_d = ST_DONE;
        case (op_q)
          OP_ADD, OP_QUERY: begin
            if (v_in_span) begin
              addr_d  = alu_sum[IDX_W-1:0];
              state_d = ST_RD;
            end else begin
              res_d.out_of_range = 1'b1;
            end
          end
          OP_MERGE: begin
            if (k_in_span) begin
              addr_d  = IDX_W'(k_q);
              state_d = ST_RD;
            end else begin
              res_d.out_of_range = 1'b1;
            end
          end
          OP_SELECT: begin
            if (!k_in_span) begin
              res_d.out_of_range = 1'b1;
            end else if (32'(distinct_q) >= 32'(span)) begin
              // Every entry of the span is occupied: the k-th value is value_min + k.
              addr_d  = IDX_W'(k_q);
              state_d = ST_VOUT;
            end else begin
              addr_d  = '0;
              seen_d  = '0;
              state_d = ST_SEL_RD;
            end
          end
          OP_CLEAR: begin
            addr_d     = '0;
            distinct_d = '0;
            reply_d    = 1'b1;
            state_d    = ST_CLEAR;
          end
          default: begin
          end
        endcase
      end

      ST_RD: begin
        mem_en  = 1'b1;
        state_d = ST_MOD;
      end

      // Saturating update of the entry that was read; a query only reports its count.
      ST_MOD: begin
        alu_a   = ALU_W'(mem_rdata);
        alu_b   = (op_q == OP_ADD) ? ALU_W'(1) : ALU_W'(mc_q);
        state_d = ST_DONE;
        if (op_q == OP_QUERY) begin
          res_d.count_out = count_field(mem_rdata);
        end else begin
          mem_en          = 1'b1;
          mem_we          = 1'b1;
          mem_wdata       = alu_sat;
          res_d.count_out = count_field(alu_sat);
          if (mem_rdata == '0 && alu_sat != '0) begin
            res_d.is_new = 1'b1;
            distinct_d   = distinct_q + DIST_W'(1);
          end
        end
      end

      ST_SEL_RD: begin
        mem_en  = 1'b1;
        state_d = ST_SEL_CHK;
      end

      // Count occupied entries in ascending order until the k-th one.
      ST_SEL_CHK: begin
        if (mem_rdata != '0 && 32'(seen_q) == 32'(k_q)) begin
          state_d = ST_VOUT;
        end else begin
          if (mem_rdata != '0) begin
            seen_d = seen_q + DIST_W'(1);
          end
          if (32'(addr_q) + 32'd1 == 32'(span)) begin
            state_d = ST_DONE;
          end else begin
            addr_d  = addr_q + IDX_W'(1);
            state_d = ST_SEL_RD;
          end
        end
      end

      // Found value is value_min plus the entry number.
      ST_VOUT: begin
        alu_a           = {{(ALU_W-VAL_W){vmin_q[VAL_W-1]}}, vmin_q};
        alu_b           = ALU_W'(addr_q);
        res_d.found     = 1'b1;
        res_d.value_out = alu_sum[VAL_W-1:0];
        state_d         = ST_DONE;
      end

      // Load the output register once it is free.
      ST_DONE: begin
        if (out_free) begin
          out_d              = res_q;
          out_d.distinct_out = DOUT_W'(distinct_q);
          out_valid_d        = 1'b1;
          reply_d            = 1'b0;
          state_d            = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers; the sequencer starts with the clearing pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      addr_q      <= '0;
      seen_q      <= '0;
      distinct_q  <= '0;
      reply_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      seen_q      <= seen_d;
      distinct_q  <= distinct_d;
      reply_q     <= reply_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    v_q   <= v_d;
    k_q   <= k_d;
    mc_q  <= mc_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_q.distinct_out, out_q.out_of_range, out_q.count_out,
                          out_q.value_out, out_q.found, out_q.is_new};

endmodule

`default_nettype wire

>>> hdl/dvcs_checker.sv
// Port checker for the distinct value count store, bound to the top level.
// Depends on dvcs_pkg and the assertion macro header.
`default_nettype none

`include "distinct_value_count_store_unit_assert.svh"

module dvcs_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  input  logic                                s_axis_tready,
  input  logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic [dvcs_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  input  logic                                cfg_ready_o
);
  import dvcs_pkg::*;

  logic is_new, found, oor;
  logic [VAL_W-1:0] value_out;
  logic [CNT_W-1:0] count_out;

  assign is_new    = m_axis_tdata[0];
  assign found     = m_axis_tdata[1];
  assign value_out = m_axis_tdata[17:2];
  assign count_out = m_axis_tdata[49:18];
  assign oor       = m_axis_tdata[50];

  // A held result keeps its contents.
  `DVCS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // Work on an item leaves no room for another in the next cycle.
  `DVCS_ASSERT_NEXT(a_busy_after_in, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while busy")

  // A select result carries no count and no update flag.
  `DVCS_ASSERT(a_found_clean, clk_i, rst_ni, !(m_axis_tvalid && found) || (!oor && !is_new && count_out == '0), "select result mixed with count fields")

  // A new entry has a nonzero count and was in the span.
  `DVCS_ASSERT(a_new_count, clk_i, rst_ni, !(m_axis_tvalid && is_new) || (count_out != '0 && !oor && !found), "new entry reported with zero count")

  // An out-of-range result changes nothing and reports no value or count.
  `DVCS_ASSERT(a_oor_zero, clk_i, rst_ni, !(m_axis_tvalid && oor) || (count_out == '0 && value_out == '0 && cfg_ready_o), "out-of-range result carries data")

endmodule

bind distinct_value_count_store_unit dvcs_checker u_dvcs_checker (.*);

`default_nettype wire

>>> dv/distinct_value_count_store_unit_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the distinct value count store: stream stimulus, a
// behavioural copy of the count table, and a field-by-field check of every result.
// Depends on dvcs_pkg and distinct_value_count_store_unit.

module distinct_value_count_store_unit_test;
  import dvcs_pkg::*;

  // Opcodes that the block must ignore.
  localparam logic [OPC_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [OPC_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OPC_W-1:0] OP_SPARE_7 = 3'd7;

  localparam int LIMIT_CYCLES     = 3000000;
  localparam int LONG_HOLD_CYCLES = 600;
  localparam int SETTLE_CYCLES    = 40;

  typedef struct {
    logic [OPC_W-1:0]        opcode;
    logic signed [VAL_W-1:0] value;
    logic [KIDX_W-1:0]       entry_index;
    logic [MC_W-1:0]         merge_count;
  } stim_t;

  typedef struct {
    stim_t item;
    bit    typed;
    res_t  want;
  } row_t;

  typedef struct {
    logic signed [VAL_W-1:0] lo;
    logic signed [VAL_W-1:0] hi;
    int                      items;
  } phase_t;

  typedef enum int {
    RX_STEADY,
    RX_COIN,
    RX_CADENCE
  } rx_mode_e;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [S_TDATA_W-1:0]   s_axis_tdata;
  logic [OPC_W-1:0]       s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [M_TDATA_W-1:0]   m_axis_tdata;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [VAL_W-1:0]       cfg_data_i;

  // Shadow of the block: counts, occupied total and span registers.
  logic [CNT_W-1:0]        tally[ENTRIES];
  int                      occupied_total;
  logic signed [VAL_W-1:0] span_lo;
  logic signed [VAL_W-1:0] span_hi;

  res_t   expected_results[$];
  row_t   directed_rows[$];
  phase_t plan[6];
  int     error_count;
  int     cycle_count;
  int     burst_left;
  int     long_holds_asked;
  int     long_holds_done;

  distinct_value_count_store_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Cycle counter and timeout.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) @(posedge clk_i);
    $display("Regression FAIL");
    $finish;
  end

  // Number of entries that the current span registers cover.
  function automatic int span_size();
    int s;
    s = int'(span_hi) - int'(span_lo) + 1;
    if (s < 0) s = 0;
    if (s > ENTRIES) s = ENTRIES;
    return s;
  endfunction

  // Adds to one entry with saturation; returns whether the entry became occupied.
  function automatic bit bump_entry(input int e, input logic [CNT_W-1:0] inc);
    logic [CNT_W:0]   sum;
    logic [CNT_W-1:0] old;
    old = tally[e];
    sum = {1'b0, old} + {1'b0, inc};
    tally[e] = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
    if (old == '0 && tally[e] != '0) begin
      occupied_total++;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Applies one operation to the shadow table and returns the result it causes.
  function automatic res_t apply_store_op(input stim_t it);
    res_t r;
    int   span;
    int   off;
    int   seen;
    bit   vin;
    r    = '0;
    span = span_size();
    off  = int'(it.value) - int'(span_lo);
    vin  = (off >= 0) && (off < span);
    case (it.opcode)
      OP_ADD: begin
        if (vin) begin
          r.is_new    = bump_entry(off, 1);
          r.count_out = tally[off];
        end else begin
          r.out_of_range = 1'b1;
        end
      end
      OP_QUERY: begin
        if (vin) r.count_out = tally[off];
        else r.out_of_range = 1'b1;
      end
      OP_SELECT: begin
        if (int'(it.entry_index) >= span) begin
          r.out_of_range = 1'b1;
        end else if (occupied_total >= span) begin
          // Every entry of the span is taken: the rank maps straight to a value.
          r.found     = 1'b1;
          r.value_out = VAL_W'(int'(span_lo) + int'(it.entry_index));
        end else begin
          seen = 0;
          for (int i = 0; i < span; i++) begin
            if (tally[i] != '0) begin
              if (seen == int'(it.entry_index)) begin
                r.found     = 1'b1;
                r.value_out = VAL_W'(int'(span_lo) + i);
                break;
              end
              seen++;
            end
          end
        end
      end
      OP_MERGE: begin
        if (int'(it.entry_index) < span) begin
          r.is_new    = bump_entry(int'(it.entry_index), it.merge_count);
          r.count_out = tally[it.entry_index];
        end else begin
          r.out_of_range = 1'b1;
        end
      end
      OP_CLEAR: begin
        foreach (tally[i]) tally[i] = '0;
        occupied_total = 0;
      end
      default: ;
    endcase
    r.distinct_out = DOUT_W'(occupied_total);
    return r;
  endfunction

  function automatic stim_t item_of(input logic [OPC_W-1:0] op, input int v, input int k,
                                    input logic [MC_W-1:0] mc);
    stim_t it;
    it.opcode      = op;
    it.value       = VAL_W'(v);
    it.entry_index = KIDX_W'(k);
    it.merge_count = mc;
    return it;
  endfunction

  function automatic res_t res_of(input bit n, input bit f, input int v,
                                  input logic [CNT_W-1:0] c, input bit o, input int d);
    res_t r;
    r.is_new       = n;
    r.found        = f;
    r.value_out    = VAL_W'(v);
    r.count_out    = c;
    r.out_of_range = o;
    r.distinct_out = DOUT_W'(d);
    return r;
  endfunction

  // Rows with a typed result are checked against it; the rest against the shadow table.
  task automatic add_row(input stim_t it, input bit typed, input res_t want);
    row_t row;
    row.item  = it;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // Random item, weighted towards values, entries and ranks inside the span.
  function automatic stim_t random_item();
    stim_t it;
    int    span;
    int    pick;
    int    k_top;
    bit    narrow;
    span   = span_size();
    narrow = (span <= 64);
    pick   = $urandom_range(0, 99);
    if (pick < (narrow ? 42 : 50))      it.opcode = OP_ADD;
    else if (pick < (narrow ? 57 : 70)) it.opcode = OP_QUERY;
    else if (pick < (narrow ? 72 : 92)) it.opcode = OP_MERGE;
    else if (pick < (narrow ? 95 : 94)) it.opcode = OP_SELECT;
    else if (pick < (narrow ? 97 : 96)) it.opcode = OP_CLEAR;
    else begin
      case ($urandom_range(0, 2))
        0:       it.opcode = OP_SPARE_5;
        1:       it.opcode = OP_SPARE_6;
        default: it.opcode = OP_SPARE_7;
      endcase
    end

    // Value: mostly inside the span, sometimes at its edges, else anything.
    pick = $urandom_range(0, 9);
    if (span > 0 && pick < 7) begin
      it.value = VAL_W'(int'(span_lo) + int'($urandom_range(0, span - 1)));
    end else if (pick < 8) begin
      case ($urandom_range(0, 3))
        0:       it.value = span_lo;
        1:       it.value = VAL_W'(int'(span_lo) + span - 1);
        2:       it.value = VAL_W'(int'(span_lo) - 1);
        default: it.value = VAL_W'(int'(span_lo) + span);
      endcase
    end else begin
      it.value = VAL_W'($urandom);
    end

    // Entry number for merge, rank for select.
    it.entry_index = KIDX_W'($urandom);
    if (span > 0 && $urandom_range(0, 3) != 0) begin
      if (it.opcode == OP_SELECT) begin
        k_top = (occupied_total + 2 < span - 1) ? occupied_total + 2 : span - 1;
        it.entry_index = KIDX_W'($urandom_range(0, k_top));
      end else begin
        it.entry_index = KIDX_W'($urandom_range(0, span - 1));
      end
    end

    case ($urandom_range(0, 3))
      0:       it.merge_count = MC_W'($urandom_range(0, 3));
      1:       it.merge_count = MC_W'($urandom_range(1, 100));
      2:       it.merge_count = '1 - MC_W'($urandom_range(0, 4));
      default: it.merge_count = MC_W'($urandom);
    endcase
    return it;
  endfunction

  // Offers one item, in bursts with random gaps, and records its expected result.
  task automatic send_item(input stim_t it, input bit typed, input res_t want);
    int   gap;
    res_t predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.opcode;
    s_axis_tdata  <= {2'b00, it.merge_count, it.entry_index, it.value};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = apply_store_op(it);
    expected_results.push_back(typed ? want : predicted);
  endtask

  // Stops offering items and waits until every expected result has been taken.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_VALUE_MIN) span_lo = data;
    else span_hi = data;
  endtask

  // Reprograms the span once the block has gone idle.
  task automatic set_span(input logic signed [VAL_W-1:0] lo, input logic signed [VAL_W-1:0] hi);
    wait_for_results();
    write_reg(CFG_VALUE_MIN, lo);
    write_reg(CFG_VALUE_MAX, hi);
    cfg_valid_i <= 1'b0;
  endtask

  // Result receiver: stall pattern of its own, plus long hold-offs on request.
  initial begin
    rx_mode_e mode;
    int       stretch;
    int       hold_left;
    int       tick;
    m_axis_tready   = 1'b0;
    long_holds_done = 0;
    stretch   = 0;
    hold_left = 0;
    tick      = 0;
    mode      = RX_STEADY;
    forever begin
      @(posedge clk_i);
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (long_holds_done < long_holds_asked) begin
        long_holds_done++;
        hold_left = LONG_HOLD_CYCLES - 1;
        m_axis_tready <= 1'b0;
      end else begin
        if (stretch == 0) begin
          mode    = rx_mode_e'($urandom_range(0, 2));
          stretch = $urandom_range(10, 150);
        end
        stretch--;
        case (mode)
          RX_STEADY: m_axis_tready <= 1'b1;
          RX_COIN:   m_axis_tready <= $urandom_range(0, 1);
          default:   m_axis_tready <= (tick % 4 != 0);
        endcase
      end
    end
  end

  // Result checker: each transfer against the oldest expectation.
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.is_new       = m_axis_tdata[0];
      got.found        = m_axis_tdata[1];
      got.value_out    = m_axis_tdata[17:2];
      got.count_out    = m_axis_tdata[49:18];
      got.out_of_range = m_axis_tdata[50];
      got.distinct_out = m_axis_tdata[65:51];
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected, tdata %h", $time, m_axis_tdata);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.is_new !== want.is_new) begin
          $display("%0t: is_new expected %0d, got %0d", $time, want.is_new, got.is_new);
          error_count++;
        end
        if (got.found !== want.found) begin
          $display("%0t: found expected %0d, got %0d", $time, want.found, got.found);
          error_count++;
        end
        if (got.value_out !== want.value_out) begin
          $display("%0t: value_out expected %0d, got %0d", $time,
                   $signed(want.value_out), $signed(got.value_out));
          error_count++;
        end
        if (got.count_out !== want.count_out) begin
          $display("%0t: count_out expected %h, got %h", $time, want.count_out,
                   got.count_out);
          error_count++;
        end
        if (got.out_of_range !== want.out_of_range) begin
          $display("%0t: out_of_range expected %0d, got %0d", $time, want.out_of_range,
                   got.out_of_range);
          error_count++;
        end
        if (got.distinct_out !== want.distinct_out) begin
          $display("%0t: distinct_out expected %0d, got %0d", $time, want.distinct_out,
                   got.distinct_out);
          error_count++;
        end
      end
    end
  end

  // Main sequence: reset, directed table, then random phases over several spans.
  initial begin
    res_t none;
    none             = '0;
    error_count      = 0;
    burst_left       = 0;
    long_holds_asked = 0;
    occupied_total   = 0;
    foreach (tally[i]) tally[i] = '0;
    span_lo       = VMIN_RST;
    span_hi       = VMAX_RST;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_ADD;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_VALUE_MIN;
    cfg_data_i    = '0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table on the reset span of -5000 to 5000.
    add_row(item_of(OP_QUERY, 0, 0, 0), 1, res_of(0, 0, 0, 0, 0, 0));
    add_row(item_of(OP_ADD, -5000, 0, 0), 1, res_of(1, 0, 0, 1, 0, 1));
    add_row(item_of(OP_ADD, 5000, 0, 0), 1, res_of(1, 0, 0, 1, 0, 2));
    add_row(item_of(OP_ADD, 5001, 0, 0), 1, res_of(0, 0, 0, 0, 1, 2));
    add_row(item_of(OP_ADD, -5001, 0, 0), 1, res_of(0, 0, 0, 0, 1, 2));
    add_row(item_of(OP_ADD, -32768, 0, 0), 1, res_of(0, 0, 0, 0, 1, 2));
    add_row(item_of(OP_QUERY, 32767, 0, 0), 1, res_of(0, 0, 0, 0, 1, 2));
    add_row(item_of(OP_ADD, 5000, 0, 0), 0, none);
    // Merging the largest count saturates the entry, and a further add keeps it there.
    add_row(item_of(OP_MERGE, 0, 10000, '1), 1, res_of(0, 0, 0, '1, 0, 2));
    add_row(item_of(OP_ADD, 5000, 0, 0), 1, res_of(0, 0, 0, '1, 0, 2));
    add_row(item_of(OP_MERGE, 0, 10001, 1), 1, res_of(0, 0, 0, 0, 1, 2));
    add_row(item_of(OP_MERGE, 0, 16383, 5), 1, res_of(0, 0, 0, 0, 1, 2));
    // A zero merge into an empty entry leaves it empty.
    add_row(item_of(OP_MERGE, 0, 1, 0), 0, none);
    add_row(item_of(OP_MERGE, 0, 2, 7), 0, none);
    add_row(item_of(OP_SELECT, 0, 0, 0), 0, none);
    add_row(item_of(OP_SELECT, 0, 2, 0), 0, none);
    add_row(item_of(OP_SELECT, 0, 3, 0), 0, none);
    add_row(item_of(OP_SELECT, 0, 10001, 0), 1, res_of(0, 0, 0, 0, 1, 3));
    add_row(item_of(OP_SELECT, 0, 16383, 0), 1, res_of(0, 0, 0, 0, 1, 3));
    add_row(item_of(OP_QUERY, -4998, 0, 0), 0, none);
    add_row(item_of(OP_SPARE_5, -1, 16383, '1), 1, res_of(0, 0, 0, 0, 0, 3));
    add_row(item_of(OP_SPARE_6, 5000, 2, 9), 1, res_of(0, 0, 0, 0, 0, 3));
    add_row(item_of(OP_SPARE_7, 0, 0, 0), 1, res_of(0, 0, 0, 0, 0, 3));
    add_row(item_of(OP_CLEAR, 0, 0, 0), 1, res_of(0, 0, 0, 0, 0, 0));
    add_row(item_of(OP_QUERY, 5000, 0, 0), 1, res_of(0, 0, 0, 0, 0, 0));
    add_row(item_of(OP_ADD, 32767, 0, 0), 1, res_of(0, 0, 0, 0, 1, 0));
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    end

    // Random phases: reset span, narrow span, widest registers, empty span,
    // a single entry at the top, and a tiny span.
    plan[0] = '{-16'sd5000, 16'sd5000, 100};
    plan[1] = '{-16'sd8, 16'sd7, 110};
    plan[2] = '{-16'sd32768, 16'sd32767, 80};
    plan[3] = '{16'sd32767, -16'sd32768, 30};
    plan[4] = '{16'sd32767, 16'sd32767, 40};
    plan[5] = '{-16'sd3, 16'sd1, 60};
    foreach (plan[p]) begin
      set_span(plan[p].lo, plan[p].hi);
      for (int n = 0; n < plan[p].items; n++) begin
        // Let every outstanding result drain once in the middle of the first phase.
        if (p == 0 && n == plan[p].items / 2) wait_for_results();
        // A long receiver hold-off while items keep coming fills the block up.
        if (p == 1 && n == 30) long_holds_asked++;
        send_item(random_item(), 0, none);
      end
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
